// ===== sv/cfd_pkg.sv =====
// Shared types and constants for the COBS frame decoder.
// Depends on nothing; every other file refers to it by scoped names.
package cfd_pkg;

  localparam int unsigned POS_W       = 9;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_LENGTH = 2'd1,
    ST_BAD_DELIM  = 2'd2,
    ST_ZERO_CODE  = 2'd3
  } status_t;

  // One result item: a decoded data byte or the frame status.
  typedef struct packed {
    logic [7:0] data;
    logic       is_status;
    status_t    status;
    logic [7:0] data_length;
    logic       last;
  } result_t;

endpackage

// ===== sv/cobs_frame_decoder_top.sv =====
// COBS frame decoder, top level.
// Depends on cfd_pkg, cfd_front, cfd_queue and cfd_back.
//
// Input channel (in_valid/in_ready): one received byte per item, with
// in_frame_end high on the frame's last byte (the stop delimiter). A frame is
// a zero start byte, a code byte, the stuffed data and a zero stop byte.
// Output channel (out_valid/out_ready): each data byte is decoded and sent as
// it arrives (out_is_status low); the stop byte yields one status item with
// out_is_status and out_last high, out_status and out_data_length. On any
// error status the receiver drops the data bytes it already got for the frame.
// Start and code bytes, and data after a bad start, a zero code or an overlong frame, give no item.
//
// Throughput: one byte per cycle while out_ready stays high. An accepted byte
// passes through a queue slot and then the output register to the output.
// The front end takes a byte whenever the two-entry result queue has room, so
// a stalled receiver first fills the output register, then the queue, and
// only then drops in_ready.
// Reset (rst_n low, synchronous) empties queue and output register and puts
// the frame tracker at the start of a new frame.
module cobs_frame_decoder_top #(
  parameter int unsigned MAX_DATA = 254
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_frame_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_status,
  output logic [1:0] out_status,
  output logic [7:0] out_data_length,
  output logic       out_last
);

  logic             push, pop, q_ready, q_valid;
  cfd_pkg::result_t push_res, q_res, out_res;

  // classify bytes and track the frame
  cfd_front #(
    .MAX_DATA(MAX_DATA)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_byte     (in_byte),
    .in_frame_end(in_frame_end),
    .q_ready     (q_ready),
    .push        (push),
    .push_res    (push_res)
  );

  // decouple front from receiver stalls
  cfd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_res(push_res),
    .q_ready (q_ready),
    .pop     (pop),
    .q_valid (q_valid),
    .q_res   (q_res)
  );

  // hold the current result until the receiver takes it
  cfd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_res    (q_res),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign in_ready        = q_ready;
  assign out_byte        = out_res.data;
  assign out_is_status   = out_res.is_status;
  assign out_status      = out_res.status;
  assign out_data_length = out_res.data_length;
  assign out_last        = out_res.last;

endmodule

// ===== sv/cfd_front.sv =====
// Front end: accepts frame bytes, tracks frame state, builds result items.
// Depends on cfd_pkg.
module cfd_front #(
  parameter int unsigned MAX_DATA = 254
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  input  logic            in_frame_end,
  input  logic            q_ready,
  output logic            push,
  output cfd_pkg::result_t push_res
);

  localparam logic [cfd_pkg::POS_W-1:0] LIMIT = cfd_pkg::POS_W'(MAX_DATA + 3);

  logic [cfd_pkg::POS_W-1:0] pos_r, pos_nxt, pos_inc;
  logic [7:0]                cd_r, cd_nxt, cd_dec;
  logic                      start_bad_r, start_bad_nxt;
  logic                      code_zero_r, code_zero_nxt;
  logic                      too_long_r, too_long_nxt;
  logic                      sub_off_r, sub_off_nxt;
  logic                      fire;

  assign fire    = in_valid && q_ready;
  assign cd_dec  = cd_r - 8'd1;
  assign pos_inc = pos_r + cfd_pkg::POS_W'(1);

  always_comb begin
    pos_nxt       = pos_r;
    cd_nxt        = cd_r;
    start_bad_nxt = start_bad_r;
    code_zero_nxt = code_zero_r;
    too_long_nxt  = too_long_r;
    sub_off_nxt   = sub_off_r;
    push          = 1'b0;
    push_res      = '0;
    if (fire) begin
      priority if (in_frame_end) begin
        push               = 1'b1;
        push_res.is_status = 1'b1;
        push_res.last      = 1'b1;
        priority if (too_long_r || pos_r < cfd_pkg::POS_W'(2)) begin
          push_res.status = cfd_pkg::ST_BAD_LENGTH;
        end else if (start_bad_r || in_byte != 8'd0) begin
          push_res.status = cfd_pkg::ST_BAD_DELIM;
        end else if (code_zero_r) begin
          push_res.status = cfd_pkg::ST_ZERO_CODE;
        end else begin
          push_res.status      = cfd_pkg::ST_OK;
          push_res.data_length = 8'(pos_r - cfd_pkg::POS_W'(2));
        end
        // back to the idle frame state for the next frame
        pos_nxt       = '0;
        cd_nxt        = '0;
        start_bad_nxt = 1'b0;
        code_zero_nxt = 1'b0;
        too_long_nxt  = 1'b0;
        sub_off_nxt   = 1'b0;
      end else if (pos_r == '0) begin
        start_bad_nxt = (in_byte != 8'd0);
        pos_nxt       = cfd_pkg::POS_W'(1);
      end else if (pos_r == cfd_pkg::POS_W'(1)) begin
        cd_nxt        = in_byte;
        code_zero_nxt = (in_byte == 8'd0);
        pos_nxt       = cfd_pkg::POS_W'(2);
      end else begin
        push          = !start_bad_r && !code_zero_r && !too_long_r;
        push_res.data = in_byte;
        if (!sub_off_r) begin
          if (cd_dec == 8'd0) begin
            // countdown expired: this byte stands for a zero and reloads
            push_res.data = 8'd0;
            cd_nxt        = in_byte;
            if (in_byte == 8'd0) begin
              sub_off_nxt = 1'b1;
            end
          end else begin
            cd_nxt = cd_dec;
          end
        end
        if (pos_r < LIMIT) begin
          pos_nxt = pos_inc;
          if (pos_inc >= LIMIT) begin
            too_long_nxt = 1'b1;
          end
        end else begin
          too_long_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      cd_r        <= '0;
      start_bad_r <= 1'b0;
      code_zero_r <= 1'b0;
      too_long_r  <= 1'b0;
      sub_off_r   <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      cd_r        <= cd_nxt;
      start_bad_r <= start_bad_nxt;
      code_zero_r <= code_zero_nxt;
      too_long_r  <= too_long_nxt;
      sub_off_r   <= sub_off_nxt;
    end
  end

endmodule

// ===== sv/cfd_queue.sv =====
// Short queue of result items between front and back end.
// Depends on cfd_pkg.
module cfd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cfd_pkg::result_t push_res,
  output logic             q_ready,
  input  logic             pop,
  output logic             q_valid,
  output cfd_pkg::result_t q_res
);

  cfd_pkg::result_t             mem_r [cfd_pkg::QUEUE_DEPTH];
  logic [cfd_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [cfd_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [cfd_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         do_push, do_pop;

  assign q_ready = (cnt_r != cfd_pkg::QCNT_W'(cfd_pkg::QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_res   = mem_r[rd_ptr_r];
  assign do_push = push && q_ready;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = wr_ptr_r + cfd_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + cfd_pkg::QPTR_W'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + cfd_pkg::QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - cfd_pkg::QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== sv/cfd_back.sv =====
// Back end: output register that hands result items to the receiver.
// Depends on cfd_pkg.
module cfd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  cfd_pkg::result_t q_res,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output cfd_pkg::result_t out_res
);

  logic             valid_r, valid_nxt;
  cfd_pkg::result_t res_r;

  // refill when the register is empty or its item leaves this cycle
  assign pop       = q_valid && (!valid_r || out_ready);
  assign valid_nxt = pop || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= q_res;
    end
  end

endmodule
